>>> design/sprc_pkg.sv
package sprc_pkg;

  // Receive and frame store depth in bytes
  localparam int BUFFER_BYTES = 256;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int SIZE_W       = $clog2(BUFFER_BYTES + 1);

  localparam logic [15:0] LEN_MIN = 16'd3;
  localparam logic [15:0] LEN_MAX = 16'(BUFFER_BYTES - 7);

  localparam logic [7:0]  HDR_FF   = 8'hFF;
  localparam logic [7:0]  HDR_FD   = 8'hFD;
  localparam logic [7:0]  HDR_00   = 8'h00;
  localparam logic [15:0] CRC_POLY = 16'h8005;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_INCOMPLETE = 3'd0,
    ST_HDR_ERR    = 3'd1,
    ST_LEN_ERR    = 3'd2,
    ST_CRC_ERR    = 3'd3,
    ST_FRAME_OK   = 3'd4,
    ST_READ       = 3'd5
  } status_t;

  // Result of one pushed byte, handed from the parser to the top level
  typedef struct packed {
    status_t             status;
    logic                commit;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [7:0]          wdata;
    logic [7:0]          id;
    logic [7:0]          instr;
    logic [7:0]          plen;
    logic [SIZE_W-1:0]   size;
  } push_res_t;

  // Expected header byte at positions 0 to 3
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = HDR_FF;
      2'd1:    v = HDR_FF;
      2'd2:    v = HDR_FD;
      default: v = HDR_00;
    endcase
    return v;
  endfunction

  // One byte into the CRC-16, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> design/sprc_ram.sv
module sprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> design/sprc_parser.sv
module sprc_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          rx_byte,
  output sprc_pkg::push_res_t res
);

  localparam int AW = sprc_pkg::ADDR_W;

  logic [AW-1:0] pos, pos_next;
  logic [AW-1:0] end_pos, end_pos_next;
  logic [15:0]   crc, crc_next;
  logic [15:0]   trail, trail_next;
  logic [7:0]    id_rx, id_rx_next;
  logic [7:0]    len_lo, len_lo_next;
  logic [7:0]    instr_rx, instr_rx_next;

  logic [15:0]   len_v;
  logic [15:0]   end_v;
  logic [15:0]   crc_v;
  logic [15:0]   trail_v;
  logic          len_ok;

  always_comb begin
    len_v   = {rx_byte, len_lo};
    end_v   = len_v + 16'd6;
    len_ok  = (len_v >= sprc_pkg::LEN_MIN) && (len_v <= sprc_pkg::LEN_MAX);
    crc_v   = (pos >= AW'(2)) ? sprc_pkg::crc_feed(crc, trail[15:8]) : crc;
    trail_v = {trail[7:0], rx_byte};

    pos_next      = pos;
    end_pos_next  = end_pos;
    crc_next      = crc;
    trail_next    = trail;
    id_rx_next    = id_rx;
    len_lo_next   = len_lo;
    instr_rx_next = instr_rx;

    res.status = sprc_pkg::ST_INCOMPLETE;
    res.commit = 1'b0;
    res.we     = 1'b0;
    res.waddr  = pos;
    res.wdata  = rx_byte;
    res.id     = id_rx;
    res.instr  = instr_rx;
    res.plen   = len_lo - 8'd3;
    res.size   = sprc_pkg::SIZE_W'(pos) + sprc_pkg::SIZE_W'(1);

    if (push) begin
      if (pos < AW'(4) && rx_byte != sprc_pkg::hdr_byte(pos[1:0])) begin
        // Drop the partial frame on a header mismatch
        res.status = sprc_pkg::ST_HDR_ERR;
        pos_next   = '0;
        crc_next   = '0;
        trail_next = '0;
      end else begin
        res.we = 1'b1;
        if (pos == AW'(4)) id_rx_next = rx_byte;
        if (pos == AW'(5)) len_lo_next = rx_byte;
        if (pos == AW'(7)) instr_rx_next = rx_byte;

        if (pos == AW'(6) && !len_ok) begin
          res.status = sprc_pkg::ST_LEN_ERR;
          pos_next   = '0;
          crc_next   = '0;
          trail_next = '0;
        end else if (pos > AW'(6) && pos == end_pos) begin
          // Last byte: check the trailing CRC, low byte first
          if ({rx_byte, trail[7:0]} == crc_v) begin
            res.status = sprc_pkg::ST_FRAME_OK;
            res.commit = 1'b1;
          end else begin
            res.status = sprc_pkg::ST_CRC_ERR;
          end
          pos_next   = '0;
          crc_next   = '0;
          trail_next = '0;
        end else begin
          if (pos == AW'(6)) end_pos_next = end_v[AW-1:0];
          pos_next   = pos + AW'(1);
          crc_next   = crc_v;
          trail_next = trail_v;
        end
      end
    end
  end

  // Hold receive state between bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      end_pos <= '0;
      crc     <= '0;
      trail   <= '0;
    end else begin
      pos     <= pos_next;
      end_pos <= end_pos_next;
      crc     <= crc_next;
      trail   <= trail_next;
    end
    id_rx    <= id_rx_next;
    len_lo   <= len_lo_next;
    instr_rx <= instr_rx_next;
  end

endmodule

>>> design/serial_packet_receiver_crc16.sv
// Serial packet receiver with CRC-16 check.
// Input channel (item_valid / item_stall): action 0 pushes rx_byte into the
// frame parser, action 1 reads byte read_index of the last good frame.
// A transfer happens when item_valid is high and item_stall is low.
// Output channel (result_valid / result_stall): one result per input
// transfer, carrying status and the id, instruction, parameter count and size
// of the last good frame.
// result_valid rises in the cycle after an input transfer; one item is
// taken every cycle while item_stall is low, the byte parser and the
// registered read of the frame store each finishing within that cycle.
// A good frame is never copied: the receive and frame stores are two banks
// that swap roles when the CRC matches.
// While result_stall is high the result is held and item_stall rises as soon
// as the result register is full; a new item is taken in the cycle the held
// result leaves.
// Reset clears the parser position and CRC state, result_valid and the stored
// frame size, so all frame fields read as zero until a good frame arrives.
module serial_packet_receiver_crc16 (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       action,
  input  logic [7:0] rx_byte,
  input  logic [7:0] read_index,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [2:0] status,
  output logic [7:0] frame_id,
  output logic [7:0] instruction,
  output logic [7:0] param_count,
  output logic [8:0] frame_size,
  output logic [7:0] read_data
);

  localparam int AW = sprc_pkg::ADDR_W;
  localparam int SW = sprc_pkg::SIZE_W;

  logic                item_acc;
  logic                push;
  logic                rd_en;
  sprc_pkg::push_res_t res;

  logic                frame_bank;
  logic [SW-1:0]       stored_size;
  logic [7:0]          stored_id;
  logic [7:0]          stored_instr;
  logic [7:0]          stored_plen;
  sprc_pkg::status_t   status_q;
  logic                rd_ok;
  logic                rd_bank;

  logic [15:0]         ridx_ext;
  logic [15:0]         size_ext;
  logic [AW-1:0]       raddr;
  logic [7:0]          q0, q1;
  logic                has_frame;

  assign item_stall = result_valid && result_stall;
  assign item_acc   = item_valid && !item_stall;
  assign push       = item_acc && (action == sprc_pkg::ACT_PUSH);
  assign rd_en      = item_acc && (action == sprc_pkg::ACT_READ);
  assign ridx_ext   = {8'h00, read_index};
  assign size_ext   = 16'(stored_size);
  assign raddr      = ridx_ext[AW-1:0];
  assign has_frame  = (stored_size != '0);

  sprc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .res     (res)
  );

  // Bank 0 and bank 1: one receives, the other holds the last good frame
  sprc_ram #(.WIDTH(8), .DEPTH(sprc_pkg::BUFFER_BYTES)) u_bank0 (
    .clk   (clk),
    .we    (res.we && frame_bank),
    .waddr (res.waddr),
    .wdata (res.wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (q0)
  );

  sprc_ram #(.WIDTH(8), .DEPTH(sprc_pkg::BUFFER_BYTES)) u_bank1 (
    .clk   (clk),
    .we    (res.we && !frame_bank),
    .waddr (res.waddr),
    .wdata (res.wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (q1)
  );

  // Swap banks and latch frame fields on a good frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bank  <= 1'b0;
      stored_size <= '0;
    end else if (res.commit) begin
      frame_bank  <= !frame_bank;
      stored_size <= res.size;
    end
    if (res.commit) begin
      stored_id    <= res.id;
      stored_instr <= res.instr;
      stored_plen  <= res.plen;
    end
  end

  // Result register: advance on transfer, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_acc) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (item_acc) begin
      status_q <= rd_en ? sprc_pkg::ST_READ : res.status;
      rd_ok    <= rd_en && (ridx_ext < size_ext);
      rd_bank  <= frame_bank;
    end
  end

  assign status      = status_q;
  assign frame_id    = has_frame ? stored_id : 8'h00;
  assign instruction = has_frame ? stored_instr : 8'h00;
  assign param_count = has_frame ? stored_plen : 8'h00;
  assign frame_size  = size_ext[8:0];
  assign read_data   = !rd_ok ? 8'h00 : (rd_bank ? q1 : q0);

endmodule
